// ----- rtl/smx_pkg.sv -----
// smx_pkg: shared types, request codes and default sizes of the sample mixer
// used by every file of the mixer but smx_ram; depends on nothing
`timescale 1ns / 1ps

package smx_pkg;

   localparam int VOICES_DEF             = 16;
   localparam int SAMPLES_DEF            = 64;
   localparam int FRAME_DEPTH_DEF        = 65536;
   localparam int MARKERS_PER_SAMPLE_DEF = 8;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [2:0] REQ_WRITE_FRAME  = 3'd0;
   localparam logic [2:0] REQ_WRITE_DESC   = 3'd1;
   localparam logic [2:0] REQ_WRITE_MARKER = 3'd2;
   localparam logic [2:0] REQ_START_VOICE  = 3'd3;
   localparam logic [2:0] REQ_TICK         = 3'd4;

   localparam logic [6:0] BG_DISABLED = 7'h7F;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_RD,
      ST_START_WR,
      ST_BG_RD,
      ST_BG_ADDR,
      ST_BG_DATA,
      ST_VOICE,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic wr_frame;
      logic wr_desc;
      logic wr_marker;
      logic start_rd;
      logic start_wr;
      logic bg_rd;
      logic bg_addr;
      logic bg_load;
      logic voice_issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } stat_type;

endpackage

// ----- rtl/smx_ram.sv -----
// smx_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/smx_ctrl.sv -----
// smx_ctrl: request sequencer of the sample mixer, drives datapath commands
// depends on smx_pkg
`timescale 1ns / 1ps

module smx_ctrl #(
   parameter int VOICES = smx_pkg::VOICES_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [2:0]                                req_tuser,
   input  smx_pkg::stat_type                         stat,
   output smx_pkg::cmd_type                          cmd,
   output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] voice_idx
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

   smx_pkg::state_type state_ff, state_in;
   logic [VW-1:0]      vcnt_ff, vcnt_in;
   logic               accept;

   assign accept    = req_tvalid && req_tready;
   assign voice_idx = vcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smx_pkg::ST_IDLE;
         vcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vcnt_ff  <= vcnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smx_pkg::ST_IDLE: begin
            if (accept && req_tuser == smx_pkg::REQ_TICK) begin
               state_in = smx_pkg::ST_BG_RD;
            end else if (accept && req_tuser == smx_pkg::REQ_START_VOICE) begin
               state_in = smx_pkg::ST_START_RD;
            end
         end
         smx_pkg::ST_START_RD: state_in = smx_pkg::ST_START_WR;
         smx_pkg::ST_START_WR: state_in = smx_pkg::ST_IDLE;
         smx_pkg::ST_BG_RD:    state_in = smx_pkg::ST_BG_ADDR;
         smx_pkg::ST_BG_ADDR:  state_in = smx_pkg::ST_BG_DATA;
         smx_pkg::ST_BG_DATA:  state_in = smx_pkg::ST_VOICE;
         smx_pkg::ST_VOICE: begin
            if (vcnt_ff == LAST_VOICE) begin
               state_in = smx_pkg::ST_DRAIN;
            end
         end
         smx_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = smx_pkg::ST_OUT;
            end
         end
         smx_pkg::ST_OUT: begin
            if (stat.out_free) begin
               state_in = smx_pkg::ST_IDLE;
            end
         end
         default: state_in = smx_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      vcnt_in    = vcnt_ff;
      case (state_ff)
         smx_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            vcnt_in       = '0;
            cmd.capture   = accept;
            cmd.wr_frame  = accept && req_tuser == smx_pkg::REQ_WRITE_FRAME;
            cmd.wr_desc   = accept && req_tuser == smx_pkg::REQ_WRITE_DESC;
            cmd.wr_marker = accept && req_tuser == smx_pkg::REQ_WRITE_MARKER;
         end
         smx_pkg::ST_START_RD: cmd.start_rd = 1'b1;
         smx_pkg::ST_START_WR: cmd.start_wr = 1'b1;
         smx_pkg::ST_BG_RD:    cmd.bg_rd    = 1'b1;
         smx_pkg::ST_BG_ADDR:  cmd.bg_addr  = 1'b1;
         smx_pkg::ST_BG_DATA:  cmd.bg_load  = 1'b1;
         smx_pkg::ST_VOICE: begin
            cmd.voice_issue = 1'b1;
            vcnt_in         = vcnt_ff + 1'b1;
         end
         smx_pkg::ST_DRAIN: ;
         smx_pkg::ST_OUT:   cmd.out_load = stat.out_free;
         default: ;
      endcase
   end

endmodule

// ----- rtl/smx_dp.sv -----
// smx_dp: datapath of the sample mixer: memories, voice state, mix pipeline,
// background register and output register; depends on smx_pkg and smx_ram
`timescale 1ns / 1ps

module smx_dp #(
   parameter int VOICES             = smx_pkg::VOICES_DEF,
   parameter int SAMPLES            = smx_pkg::SAMPLES_DEF,
   parameter int FRAME_DEPTH        = smx_pkg::FRAME_DEPTH_DEF,
   parameter int MARKERS_PER_SAMPLE = smx_pkg::MARKERS_PER_SAMPLE_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  smx_pkg::cmd_type                          cmd,
   input  logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] voice_idx,
   output smx_pkg::stat_type                         stat,
   input  logic [smx_pkg::REQ_DATA_W-1:0]            req_tdata,
   input  logic                                      csr_wr,
   input  logic [6:0]                                csr_wdata,
   output logic [6:0]                                bg_cfg,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [smx_pkg::RSP_DATA_W-1:0]            rsp_tdata
);

   localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int FAW  = $clog2(FRAME_DEPTH);
   localparam int MDEP = SAMPLES * MARKERS_PER_SAMPLE;
   localparam int MAW  = (MDEP > 1) ? $clog2(MDEP) : 1;

   // request fields straight from the port (writes) and captured (start)
   logic [15:0]        f_address, f_left, f_right, f_slen, f_mstart, f_mend;
   logic [7:0]         f_sid;
   logic [3:0]         f_mcount, f_track;
   logic [8:0]         f_midx;

   assign f_address = req_tdata[15:0];
   assign f_left    = req_tdata[31:16];
   assign f_right   = req_tdata[47:32];
   assign f_sid     = req_tdata[55:48];
   assign f_slen    = req_tdata[71:56];
   assign f_mcount  = req_tdata[75:72];
   assign f_midx    = req_tdata[84:76];
   assign f_mstart  = req_tdata[100:85];
   assign f_mend    = req_tdata[116:101];
   assign f_track   = req_tdata[120:117];

   logic [7:0]  sid_ff;
   logic [8:0]  midx_ff;
   logic [3:0]  track_ff;
   logic [15:0] volume_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sid_ff    <= f_sid;
         midx_ff   <= f_midx;
         track_ff  <= f_track;
         volume_ff <= req_tdata[136:121];
      end
   end

   function automatic logic sid_valid(input logic [7:0] sid);
      sid_valid = !sid[7] && ({1'b0, sid} < 9'(SAMPLES));
   endfunction

   function automatic logic [MAW-1:0] marker_addr(input logic [7:0] sid, input logic [8:0] midx);
      logic [15:0] flat;
      flat = 16'(sid) * 16'(MARKERS_PER_SAMPLE) + 16'(midx[7:0]);
      marker_addr = flat[MAW-1:0];
   endfunction

   // background register
   logic [6:0] bg_ff;
   logic       bg_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= smx_pkg::BG_DISABLED;
      end else if (csr_wr) begin
         bg_ff <= csr_wdata;
      end
   end

   assign bg_cfg = bg_ff;
   assign bg_en  = !bg_ff[6] && ({2'b0, bg_ff} < 9'(SAMPLES));

   // descriptor table: ram plus a valid bit per sample (unwritten reads zero)
   logic [SAMPLES-1:0] dvld_ff;
   logic               dvld_rd_ff;
   logic [SW-1:0]      d_raddr;
   logic [35:0]        d_rdata, d_eff;
   logic               d_wen;
   logic [SW-1:0]      d_waddr;

   assign d_wen   = cmd.wr_desc && sid_valid(f_sid);
   assign d_waddr = f_sid[SW-1:0];

   smx_ram #(.WIDTH(36), .DEPTH(SAMPLES)) u_desc_ram (
      .clock   (clock),
      .wr_en   (d_wen),
      .wr_addr (d_waddr),
      .wr_data ({f_mcount, f_slen, f_address}),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else if (d_wen) begin
         dvld_ff[d_waddr] <= 1'b1;
      end
      dvld_rd_ff <= dvld_ff[d_raddr];
   end

   assign d_eff = dvld_rd_ff ? d_rdata : '0;

   // marker table
   logic [31:0] m_rdata;
   logic        m_wen;

   assign m_wen = cmd.wr_marker && sid_valid(f_sid) && !f_midx[8]
                  && (f_midx < 9'(MARKERS_PER_SAMPLE));

   smx_ram #(.WIDTH(32), .DEPTH(MDEP)) u_marker_ram (
      .clock   (clock),
      .wr_en   (m_wen),
      .wr_addr (marker_addr(f_sid, f_midx)),
      .wr_data ({f_mend, f_mstart}),
      .rd_addr (marker_addr(sid_ff, midx_ff)),
      .rd_data (m_rdata)
   );

   // frame memory, addresses wrap on the power-of-two depth
   logic [FAW-1:0] fr_raddr;
   logic [31:0]    fr_rdata;
   logic [20:0]    fr_waddr_x;

   assign fr_waddr_x = 21'(f_address);

   smx_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_frame),
      .wr_addr (fr_waddr_x[FAW-1:0]),
      .wr_data ({f_right, f_left}),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   // voice state
   logic              act_ff [VOICES];
   logic [SW-1:0]     smp_ff [VOICES];
   logic [15:0]       gain_ff[VOICES];
   logic [15:0]       pos_ff [VOICES];
   logic [15:0]       end_ff [VOICES];
   logic [15:0]       bgpos_ff;

   logic              trk_ok, use_mark;
   logic [7:0]        trk_x;
   logic [VW-1:0]     trk_idx;
   logic [6:0]        cnt_lim;
   logic              a_fire, a_stop;

   assign trk_x   = 8'(track_ff);
   assign trk_idx = trk_x[VW-1:0];
   assign trk_ok  = 7'(track_ff) < 7'(VOICES);
   assign cnt_lim = (7'(d_eff[35:32]) > 7'(MARKERS_PER_SAMPLE))
                    ? 7'(MARKERS_PER_SAMPLE) : 7'(d_eff[35:32]);
   assign use_mark = !midx_ff[8] && (midx_ff < 9'(cnt_lim));

   assign a_fire = act_ff[voice_idx] && (pos_ff[voice_idx] < end_ff[voice_idx]);
   assign a_stop = act_ff[voice_idx] && !(pos_ff[voice_idx] < end_ff[voice_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            act_ff[v]  <= 1'b0;
            smp_ff[v]  <= '0;
            gain_ff[v] <= '0;
            pos_ff[v]  <= '0;
            end_ff[v]  <= '0;
         end
      end else if (cmd.start_wr && trk_ok) begin
         gain_ff[trk_idx] <= volume_ff;
         if (!sid_valid(sid_ff)) begin
            act_ff[trk_idx] <= 1'b0;
            pos_ff[trk_idx] <= '0;
            end_ff[trk_idx] <= '0;
         end else begin
            act_ff[trk_idx] <= 1'b1;
            smp_ff[trk_idx] <= sid_ff[SW-1:0];
            if (use_mark) begin
               pos_ff[trk_idx] <= m_rdata[15:0];
               end_ff[trk_idx] <= m_rdata[31:16];
            end else begin
               pos_ff[trk_idx] <= '0;
               end_ff[trk_idx] <= d_eff[31:16];
            end
         end
      end else if (cmd.voice_issue) begin
         if (a_stop) begin
            act_ff[voice_idx] <= 1'b0;
         end
         if (a_fire) begin
            pos_ff[voice_idx] <= pos_ff[voice_idx] + 16'd1;
         end
      end
   end

   // descriptor read address
   always_comb begin
      if (cmd.start_rd) begin
         d_raddr = sid_ff[SW-1:0];
      end else if (cmd.bg_rd) begin
         d_raddr = bg_ff[SW-1:0];
      end else begin
         d_raddr = smp_ff[voice_idx];
      end
   end

   // background position
   logic [15:0] bg_len, bg_cur, bg_nxt;
   logic        bg_hit_ff;
   logic [16:0] bg_faddr;

   assign bg_len   = d_eff[31:16];
   assign bg_cur   = (bgpos_ff >= bg_len) ? 16'd0 : bgpos_ff;
   assign bg_nxt   = ((17'(bg_cur) + 17'd1) >= 17'(bg_len)) ? 16'd0 : (bg_cur + 16'd1);
   assign bg_faddr = 17'(d_eff[15:0]) + 17'(bg_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         bgpos_ff <= '0;
      end else if (cmd.bg_addr && bg_en) begin
         bgpos_ff <= (bg_len == 16'd0) ? 16'd0 : bg_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bg_addr) begin
         bg_hit_ff <= bg_en && (bg_len != 16'd0);
      end
   end

   // voice pipeline: a desc read, b frame read, c multiply, d divide, then mix
   logic               va_ff, vb_ff, vc_ff, vd_ff;
   logic [15:0]        pa_ff, ga_ff, gb_ff;
   logic signed [32:0] pl_ff, pr_ff;
   logic signed [16:0] ql_ff, qr_ff;
   logic [16:0]        v_faddr;
   logic [20:0]        faddr_x;

   assign v_faddr = 17'(d_eff[15:0]) + 17'(pa_ff);
   assign faddr_x = cmd.bg_addr ? 21'(bg_faddr) : 21'(v_faddr);
   assign fr_raddr = faddr_x[FAW-1:0];

   // truncating division by 65535 on the magnitude
   function automatic logic signed [16:0] div_65535(input logic signed [32:0] p);
      logic [31:0] mag;
      logic [32:0] sum;
      logic [16:0] q;
      mag = p[32] ? 32'(-p) : p[31:0];
      sum = 33'(mag) + 33'(mag[31:16]) + 33'd1;
      q   = sum[32:16];
      div_65535 = p[32] ? -$signed(q) : $signed(q);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= cmd.voice_issue && a_fire;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff <= pos_ff[voice_idx];
      ga_ff <= gain_ff[voice_idx];
      gb_ff <= ga_ff;
      pl_ff <= $signed(fr_rdata[15:0]) * $signed({1'b0, gb_ff});
      pr_ff <= $signed(fr_rdata[31:16]) * $signed({1'b0, gb_ff});
      ql_ff <= div_65535(pl_ff);
      qr_ff <= div_65535(pr_ff);
   end

   assign stat.pipe_busy = va_ff || vb_ff || vc_ff || vd_ff;

   // mix accumulator, clamped after every voice
   logic signed [15:0] accl_ff, accr_ff;
   logic signed [17:0] suml, sumr;

   function automatic logic signed [15:0] clamp_mix(input logic signed [17:0] s);
      if (s < -18'sd32767) begin
         clamp_mix = -16'sd32767;
      end else if (s > 18'sd32767) begin
         clamp_mix = 16'sd32767;
      end else begin
         clamp_mix = s[15:0];
      end
   endfunction

   assign suml = 18'(accl_ff) + 18'(ql_ff);
   assign sumr = 18'(accr_ff) + 18'(qr_ff);

   always_ff @(posedge clock) begin
      if (cmd.bg_load) begin
         accl_ff <= bg_hit_ff ? fr_rdata[15:0]  : 16'sd0;
         accr_ff <= bg_hit_ff ? fr_rdata[31:16] : 16'sd0;
      end else if (vd_ff) begin
         accl_ff <= clamp_mix(suml);
         accr_ff <= clamp_mix(sumr);
      end
   end

   // output register
   logic                          rsp_valid_ff;
   logic [smx_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {accr_ff, accl_ff};
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

endmodule

// ----- rtl/multi_track_sample_mixer.sv -----
// multi_track_sample_mixer: top level of the stereo sample mixer
// depends on smx_pkg, smx_ctrl, smx_dp and smx_ram
`timescale 1ns / 1ps

// Stereo sample player with VOICES voices. Write-frame, write-descriptor and
// write-marker requests are written as they are taken; start-voice reads the
// descriptor and marker, then updates the voice. A tick fetches the looping
// background frame through its descriptor read, address and data states, then
// one voice enters the mix pipeline per cycle through the single read port of
// the descriptor and frame memories, and the pipeline drains through multiply,
// divide by 65535 and clamp. The mixed frame sits in an output register, so
// new requests are taken while it waits. FRAME_DEPTH must be a power of two;
// frame addresses wrap on it. The background is off after reset (register 0
// reads -1).
module multi_track_sample_mixer #(
   parameter int VOICES             = smx_pkg::VOICES_DEF,
   parameter int SAMPLES            = smx_pkg::SAMPLES_DEF,
   parameter int FRAME_DEPTH        = smx_pkg::FRAME_DEPTH_DEF,
   parameter int MARKERS_PER_SAMPLE = smx_pkg::MARKERS_PER_SAMPLE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address, left_in, right_in, sample_id, sample_len, marker_count,
   // marker_idx, marker_start, marker_end, track, volume, zero pad
   input  logic [smx_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // left_out, right_out
   output logic [smx_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [smx_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

   smx_pkg::cmd_type  cmd;
   smx_pkg::stat_type stat;
   logic [VW-1:0]     voice_idx;
   logic              csr_wr;
   logic [6:0]        bg_cfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{25{bg_cfg[6]}}, bg_cfg};

   smx_ctrl #(.VOICES(VOICES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd),
      .voice_idx  (voice_idx)
   );

   smx_dp #(
      .VOICES             (VOICES),
      .SAMPLES            (SAMPLES),
      .FRAME_DEPTH        (FRAME_DEPTH),
      .MARKERS_PER_SAMPLE (MARKERS_PER_SAMPLE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .voice_idx  (voice_idx),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_wr     (csr_wr),
      .csr_wdata  (csr_pwdata[6:0]),
      .bg_cfg     (bg_cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- test/multi_track_sample_mixer_check.sv -----
// multi_track_sample_mixer_check: watches the request, result and register ports of the mixer
// keeps its own copy of the mixer state, predicts each tick's frame and compares; uses smx_pkg
`timescale 1ns / 1ps

module multi_track_sample_mixer_check #(
   parameter logic [smx_pkg::CSR_ADDR_W-1:0] BG_REG_ADDR = '0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [smx_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [2:0]                        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [smx_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [smx_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int                                failures,
   output int                                frames_owed
);
   import smx_pkg::*;

   localparam int NV = VOICES_DEF;
   localparam int NS = SAMPLES_DEF;
   localparam int NM = MARKERS_PER_SAMPLE_DEF;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stereo_frame_t;

   logic [31:0]        frame_mem [FRAME_DEPTH_DEF];
   logic [15:0]        desc_base [NS];
   logic [15:0]        desc_len [NS];
   logic [3:0]         desc_cnt [NS];
   logic [31:0]        marker_mem [NS*NM];
   logic               v_active [NV];
   logic [5:0]         v_sample [NV];
   logic [15:0]        v_gain [NV];
   logic [15:0]        v_pos [NV];
   logic [15:0]        v_end [NV];
   logic [15:0]        bg_pos;
   logic signed [6:0]  bg_sel;
   stereo_frame_t      mixed_q[$];

   function automatic int clamp_mix(int x);
      if (x < -32767) return -32767;
      if (x > 32767) return 32767;
      return x;
   endfunction

   task automatic mix_tick(output stereo_frame_t res);
      int     left, right, bg;
      longint a, b, g;
      logic [31:0] f;
      logic [15:0] addr;
      left = 0;
      right = 0;
      bg = bg_sel;
      if (bg >= 0 && bg < NS) begin
         if (desc_len[bg] == 0) begin
            bg_pos = 0;
         end else begin
            if (bg_pos >= desc_len[bg]) bg_pos = 0;
            addr = desc_base[bg] + bg_pos;
            f = frame_mem[addr];
            left = $signed(f[15:0]);
            right = $signed(f[31:16]);
            bg_pos = bg_pos + 1;
            if (bg_pos >= desc_len[bg]) bg_pos = 0;
         end
      end
      for (int v = 0; v < NV; v++) begin
         if (!v_active[v]) continue;
         if (v_pos[v] >= v_end[v]) begin
            v_active[v] = 1'b0;
            continue;
         end
         addr = desc_base[v_sample[v]] + v_pos[v];
         f = frame_mem[addr];
         a = $signed(f[15:0]);
         b = $signed(f[31:16]);
         g = v_gain[v];
         left = clamp_mix(left + int'(a * g / 65535));
         right = clamp_mix(right + int'(b * g / 65535));
         v_pos[v] = v_pos[v] + 16'd1;
      end
      res.left = left[15:0];
      res.right = right[15:0];
   endtask

   task automatic apply_word(logic [2:0] kind, logic [REQ_DATA_W-1:0] d);
      logic [15:0]        address, slen, mstart, mend, volume;
      logic signed [7:0]  sid;
      logic [3:0]         mcount, track, cnt;
      logic signed [8:0]  midx;
      logic               sid_ok;
      logic [31:0]        m;
      stereo_frame_t      res;
      address = d[15:0];
      sid = d[55:48];
      slen = d[71:56];
      mcount = d[75:72];
      midx = d[84:76];
      mstart = d[100:85];
      mend = d[116:101];
      track = d[120:117];
      volume = d[136:121];
      sid_ok = sid >= 0 && sid < NS;
      case (kind)
         REQ_WRITE_FRAME: frame_mem[address] = d[47:16];
         REQ_WRITE_DESC: begin
            if (sid_ok) begin
               desc_base[sid] = address;
               desc_len[sid] = slen;
               desc_cnt[sid] = mcount;
            end
         end
         REQ_WRITE_MARKER: begin
            if (sid_ok && midx >= 0 && midx < NM) marker_mem[sid*NM + midx] = {mend, mstart};
         end
         REQ_START_VOICE: begin
            if (track < NV) begin
               v_gain[track] = volume;
               v_pos[track] = 0;
               v_end[track] = 0;
               if (!sid_ok) begin
                  v_active[track] = 1'b0;
               end else begin
                  cnt = (desc_cnt[sid] > NM) ? 4'(NM) : desc_cnt[sid];
                  v_sample[track] = sid[5:0];
                  v_active[track] = 1'b1;
                  v_end[track] = desc_len[sid];
                  if (midx >= 0 && midx < cnt) begin
                     m = marker_mem[sid*NM + midx];
                     v_pos[track] = m[15:0];
                     v_end[track] = m[31:16];
                  end
               end
            end
         end
         REQ_TICK: begin
            mix_tick(res);
            mixed_q.push_back(res);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      stereo_frame_t exp_f;
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            desc_base[i] = 0;
            desc_len[i] = 0;
            desc_cnt[i] = 0;
         end
         for (int v = 0; v < NV; v++) begin
            v_active[v] = 0;
            v_sample[v] = 0;
            v_gain[v] = 0;
            v_pos[v] = 0;
            v_end[v] = 0;
         end
         bg_pos = 0;
         bg_sel = -1;
         mixed_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (mixed_q.size() == 0) begin
               $error("result word with no frame expected: %h", rsp_tdata);
               failures++;
            end else begin
               exp_f = mixed_q.pop_front();
               if ($signed(rsp_tdata[15:0]) !== exp_f.left) begin
                  $error("left_out expected %0d actual %0d", exp_f.left,
                         $signed(rsp_tdata[15:0]));
                  failures++;
               end
               if ($signed(rsp_tdata[31:16]) !== exp_f.right) begin
                  $error("right_out expected %0d actual %0d", exp_f.right,
                         $signed(rsp_tdata[31:16]));
                  failures++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == BG_REG_ADDR)
            bg_sel = csr_pwdata[6:0];
         if (req_tvalid && req_tready) apply_word(req_tuser, req_tdata);
      end
      frames_owed = mixed_q.size();
   end

   initial begin
      failures = 0;
      frames_owed = 0;
   end

endmodule

// ----- test/multi_track_sample_mixer_test.sv -----
// multi_track_sample_mixer_test: top of the mixer testbench, clock, reset, stimulus and verdict
// depends on smx_pkg, multi_track_sample_mixer and multi_track_sample_mixer_check
`timescale 1ns / 1ps

module multi_track_sample_mixer_test;
   import smx_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_BACKGROUND = 3'd0;
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
   localparam int TICK_BUDGET = 240;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [2:0]         kind;
      logic [15:0]        address;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [7:0]  sid;
      logic [15:0]        len;
      logic [3:0]         cnt;
      logic signed [8:0]  midx;
      logic [15:0]        mstart;
      logic [15:0]        mend;
      logic [3:0]         track;
      logic [15:0]        volume;
   } mixer_word_t;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   // address, left_in, right_in, sample_id, sample_len, marker_count,
   // marker_idx, marker_start, marker_end, track, volume, zero pad
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // req_type
   logic [2:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   // left_out, right_out
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel = 0;
   logic                   csr_penable = 0;
   logic                   csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int   failures, frames_owed;
   int   cycles = 0;
   int   ticks_sent = 0;
   bit   calm = 0;
   bit   bursty = 1;
   bit   hold_rsp = 0;
   logic [3:0] cnt_seen [SAMPLES_DEF];
   bit   marker_set [SAMPLES_DEF*MARKERS_PER_SAMPLE_DEF];

   multi_track_sample_mixer dut (.*);

   multi_track_sample_mixer_check #(.BG_REG_ADDR(CSR_BACKGROUND)) check (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("multi_track_sample_mixer_test: FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!calm && bursty && $urandom_range(4) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(mixer_word_t w);
      req_tuser <= w.kind;
      req_tdata <= {7'b0, w.volume, w.track, w.mend, w.mstart, w.midx, w.cnt, w.len,
                    w.sid, w.right, w.left, w.address};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      if (w.kind == REQ_TICK) ticks_sent++;
      if (!calm && bursty && $urandom_range(3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   function automatic mixer_word_t blank(logic [2:0] kind);
      mixer_word_t w;
      w = '{kind: kind, default: '0};
      w.midx = -1;
      return w;
   endfunction

   task automatic put_frame(logic [15:0] a, int l, int r);
      mixer_word_t w;
      w = blank(REQ_WRITE_FRAME);
      w.address = a;
      w.left = l;
      w.right = r;
      send_word(w);
   endtask

   task automatic put_desc(int sid, logic [15:0] base, logic [15:0] len, int cnt);
      mixer_word_t w;
      w = blank(REQ_WRITE_DESC);
      w.sid = sid;
      w.address = base;
      w.len = len;
      w.cnt = cnt;
      if (sid >= 0 && sid < SAMPLES_DEF) cnt_seen[sid] = cnt;
      send_word(w);
   endtask

   task automatic put_marker(int sid, int idx, logic [15:0] s, logic [15:0] e);
      mixer_word_t w;
      w = blank(REQ_WRITE_MARKER);
      w.sid = sid;
      w.midx = idx;
      w.mstart = s;
      w.mend = e;
      if (sid >= 0 && sid < SAMPLES_DEF && idx >= 0 && idx < MARKERS_PER_SAMPLE_DEF)
         marker_set[sid*MARKERS_PER_SAMPLE_DEF + idx] = 1;
      send_word(w);
   endtask

   // a chunk whose marker was never written falls back to the whole sample
   task automatic start_voice(int track, int sid, int idx, logic [15:0] vol);
      mixer_word_t w;
      int          lim;
      w = blank(REQ_START_VOICE);
      if (sid >= 0 && sid < SAMPLES_DEF) begin
         lim = (cnt_seen[sid] > MARKERS_PER_SAMPLE_DEF) ? MARKERS_PER_SAMPLE_DEF
                                                        : cnt_seen[sid];
         if (idx >= 0 && idx < lim && !marker_set[sid*MARKERS_PER_SAMPLE_DEF + idx]) idx = -1;
      end
      w.track = track;
      w.sid = sid;
      w.midx = idx;
      w.volume = vol;
      send_word(w);
   endtask

   task automatic tick();
      send_word(blank(REQ_TICK));
   endtask

   task automatic write_background(int value);
      logic [6:0] v;
      v = value;
      req_tvalid <= 0;
      wait (frames_owed == 0);
      repeat (40) @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= CSR_BACKGROUND;
      csr_pwdata <= {{25{v[6]}}, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   function automatic int rand_pcm();
      return int'($urandom_range(65534)) - 32767;
   endfunction

   // read addresses stay in the preloaded windows: bases near either end, short positions
   function automatic logic [15:0] rand_base();
      if ($urandom_range(1)) return 16'($urandom_range(127));
      return 16'(65408 + $urandom_range(127));
   endfunction

   function automatic int rand_sid();
      if ($urandom_range(9) == 0) return int'($urandom_range(255)) - 128;
      return $urandom_range(SAMPLES_DEF - 1);
   endfunction

   task automatic random_word();
      int pick, sid, idx;
      logic [15:0] s, vol;
      pick = $urandom_range(99);
      if (pick >= 80 && pick < 95 && ticks_sent >= TICK_BUDGET) pick = 0;
      if (pick < 25) begin
         put_frame(16'($urandom), rand_pcm(), rand_pcm());
      end else if (pick < 40) begin
         put_desc(rand_sid(), rand_base(),
                  ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                  $urandom_range(8));
      end else if (pick < 60) begin
         idx = ($urandom_range(4) == 0) ? int'($urandom_range(256)) - 1
                                        : $urandom_range(MARKERS_PER_SAMPLE_DEF - 1);
         if ($urandom_range(4) < 3) begin
            put_marker(rand_sid(), idx, 16'($urandom_range(127)), 16'($urandom));
         end else begin
            s = 16'($urandom);
            put_marker(rand_sid(), idx, s, 16'($urandom_range(s)));
         end
      end else if (pick < 80) begin
         sid = rand_sid();
         idx = ($urandom_range(9) == 0) ? int'($urandom_range(256)) - 1
                                        : int'($urandom_range(9)) - 1;
         case ($urandom_range(9))
            0, 1: vol = 16'hFFFF;
            2: vol = 0;
            default: vol = 16'($urandom);
         endcase
         start_voice($urandom_range(15), sid, idx, vol);
      end else if (pick < 95) begin
         tick();
      end else begin
         send_word(blank(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))));
      end
   endtask

   initial begin
      int bg_plan [5];
      bg_plan = '{0, 63, 5, -1, 17};
      repeat (7) @(posedge clock);
      reset <= 0;

      // preload the frame windows that sample bases may point into
      for (int a = 0; a < 384; a++) put_frame(16'(a), rand_pcm(), rand_pcm());
      for (int a = 65408; a < 65536; a++) put_frame(16'(a), rand_pcm(), rand_pcm());
      put_frame(16'd0, 32767, -32767);
      put_frame(16'd1, -32767, 32767);

      put_desc(0, 16'd0, 16'd16, 2);
      put_desc(63, 16'd65530, 16'd20, 8);
      put_desc(1, 16'd100, 16'd0, 0);
      put_desc(2, 16'd127, 16'hFFFF, 8);
      put_desc(-128, 16'hFFFF, 16'hFFFF, 8);
      put_desc(127, 16'd5, 16'd5, 1);
      put_marker(0, 0, 16'd2, 16'd6);
      put_marker(0, 1, 16'hFFFF, 16'd0);
      put_marker(63, 7, 16'd0, 16'hFFFF);
      put_marker(0, -1, 16'd1, 16'd2);
      put_marker(0, 255, 16'd1, 16'd2);
      put_marker(-1, 0, 16'd1, 16'd2);
      start_voice(0, 0, 0, 16'hFFFF);
      start_voice(15, 63, 7, 16'd0);
      start_voice(1, 0, 1, 16'hFFFF);
      start_voice(2, 0, 5, 16'hFFFF);
      start_voice(3, -128, -1, 16'd12345);
      start_voice(4, 2, -1, 16'd32768);
      start_voice(5, 63, 255, 16'hFFFF);
      start_voice(6, 127, 0, 16'hFFFF);
      send_word(blank(REQ_UNUSED_LO));
      send_word(blank(REQ_UNUSED_HI));
      repeat (4) tick();

      for (int ph = 0; ph < 5; ph++) begin
         write_background(bg_plan[ph]);
         for (int n = 0; n < 230; n++) begin
            if (n % 60 == 0) bursty = $urandom_range(1);
            if (ph == 1 && n == 100) begin
               // result side holds off while ticks keep coming
               hold_rsp = 1;
               repeat (10) tick();
            end
            if (ph == 2 && n == 100) begin
               req_tvalid <= 0;
               wait (frames_owed == 0);
               @(posedge clock);
            end
            if (ph == 4 && n == 150) calm = 1;
            random_word();
         end
      end

      req_tvalid <= 0;
      wait (frames_owed == 0);
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("multi_track_sample_mixer_test: PASS");
      end else begin
         $display("multi_track_sample_mixer_test: FAIL");
      end
      $finish;
   end

endmodule

// ----- multi_track_sample_mixer.f -----
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_ctrl.sv
rtl/smx_dp.sv
rtl/multi_track_sample_mixer.sv
test/multi_track_sample_mixer_check.sv
test/multi_track_sample_mixer_test.sv
